// ===== src/pcrm_pkg.sv =====
package pcrm_pkg;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] resource_id;
		logic [3:0] task_id;
		logic [7:0] isr_level;
		logic [7:0] task_prio;
		logic [7:0] resource_prio;
		logic       has_internal;
		logic [7:0] internal_prio;
	} pcrm_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] current_prio;
		logic       reschedule;
	} pcrm_rsp_t;

	localparam logic [1:0] MODE_GET     = 2'd0;
	localparam logic [1:0] MODE_REL     = 2'd1;
	localparam logic [1:0] MODE_GET_INT = 2'd2;
	localparam logic [1:0] MODE_REL_INT = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ID     = 2'd1;
	localparam logic [1:0] ST_ACCESS = 2'd2;
	localparam logic [1:0] ST_NOFUNC = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_TOP,
		S_CHECK,
		S_SCAN,
		S_DONE
	} pcrm_state_t;

endpackage

// ===== src/priority_ceiling_resource_manager_core.sv =====
// Get, internal and error requests pass READ, TOP, CHECK and DONE; a release with more
// than one entry on the stack and an internal release with a non-empty stack add a SCAN
// of the stack entries, set by the single compare unit walking the stack memory one entry
// a cycle. A new request is taken only in idle, once the last is done; busy is high from
// the cycle after accept and drops as done rises.
// Reset clears taken flags, fill counts, task priorities and extended_checks = 1;
// stack memory is not cleared. The receiver cannot stall: done is a 1-cycle strobe.
module priority_ceiling_resource_manager_core import pcrm_pkg::*; #(
	parameter int NUM_RESOURCES = 16,
	parameter int NUM_TASKS     = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  pcrm_req_t req,
	output logic      done,
	output pcrm_rsp_t rsp,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);
	localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int FW = $clog2(NUM_RESOURCES + 1);
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int NCTX = NUM_TASKS + 1;
	localparam int AW = $clog2(NCTX * NUM_RESOURCES);

	pcrm_state_t state_q, state_d;
	pcrm_req_t   req_q;
	logic        ext_q;
	logic [NUM_RESOURCES-1:0] taken_q;
	logic [FW-1:0] fill_q [NCTX];
	logic [7:0]    prio_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] int_q;
	logic [RW+7:0] stk_mem [NCTX * NUM_RESOURCES];
	logic [RW+7:0] rd_q;
	logic [FW-1:0] k_q, lim_q, n_q;
	logic [CW-1:0] ctx_q;
	logic [1:0]    st_q;
	logic          commit_q;
	logic          vld_q;
	pcrm_rsp_t     rsp_q;
	logic          done_q;

	logic tvalid, rvalid, is_isr, prio_bad, m_ld, m_step;
	logic task_ctx, top_ok, chk_ok;
	logic [1:0] chk_st;
	logic [FW-1:0] fill_sel;
	logic [7:0] m_base, m_acc;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [RW-1:0] rid;
	logic [3:0] tid;

	assign tid    = req_q.task_id;
	assign tvalid = 32'(tid) < NUM_TASKS;
	assign rvalid = 32'(req_q.resource_id) < NUM_RESOURCES;
	assign is_isr = req_q.isr_level != 8'd0;
	assign rid    = req_q.resource_id[RW-1:0];
	assign prio_bad = is_isr ? (req_q.isr_level > req_q.resource_prio)
		: (req_q.task_prio > req_q.resource_prio);
	assign task_ctx = req_q.mode[1] || !is_isr;
	assign fill_sel = task_ctx ? (tvalid ? fill_q[CW'(tid)] : '0) : fill_q[CW'(NUM_TASKS)];
	assign top_ok  = !(ext_q && rd_q[RW+7:8] != rid);
	assign rd_addr = AW'(32'(ctx_q) * NUM_RESOURCES + 32'(k_q));
	assign wr_addr = AW'(32'(ctx_q) * NUM_RESOURCES + 32'(n_q));

	pcrm_max_unit u_max (
		.clk(clk), .load(m_ld), .load_val(m_base),
		.step(m_step), .step_val(rd_q[7:0]), .acc(m_acc)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_READ;
			S_READ:  state_d = S_TOP;
			S_TOP:   state_d = S_CHECK;
			S_CHECK: state_d = (commit_q && lim_q != '0 && (req_q.mode != MODE_REL || top_ok))
				? S_SCAN : S_DONE;
			S_SCAN:  if (k_q >= lim_q) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy   = state_q != S_IDLE;
		m_ld   = state_q == S_READ;
		m_step = state_q == S_SCAN && vld_q;
		m_base = (req_q.mode == MODE_REL && req_q.has_internal) ?
			req_q.internal_prio : req_q.task_prio;
	end

	// request checks that need no stack data
	always_comb begin
		chk_st = ST_OK;
		chk_ok = 1'b0;
		if (req_q.mode[1]) begin
			if (!tvalid) chk_st = ST_ID;
			else if (req_q.has_internal) chk_ok = 1'b1;
		end else if (!rvalid || (!is_isr && !tvalid)) begin
			chk_st = ST_ID;
		end else if (req_q.mode == MODE_GET) begin
			if (ext_q && (taken_q[rid] || prio_bad)) chk_st = ST_ACCESS;
			else chk_ok = 1'b1;
		end else begin
			if (ext_q && !taken_q[rid]) chk_st = ST_NOFUNC;
			else if (ext_q && prio_bad) chk_st = ST_ACCESS;
			else chk_ok = 1'b1;
		end
	end

	assign cfg_ready = state_q == S_IDLE && !start;

	// stack memory: read one entry a cycle, push on commit of a get
	always_ff @(posedge clk) begin
		rd_q <= stk_mem[rd_addr];
		if (state_q == S_CHECK && commit_q && req_q.mode == MODE_GET)
			stk_mem[wr_addr] <= {rid, req_q.resource_prio};
	end

	// capture request, decide and update state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			ext_q    <= 1'b1;
			taken_q  <= '0;
			int_q    <= '0;
			done_q   <= 1'b0;
			commit_q <= 1'b0;
			vld_q    <= 1'b0;
			k_q      <= '0;
			lim_q    <= '0;
			n_q      <= '0;
			ctx_q    <= '0;
			st_q     <= ST_OK;
			rsp_q    <= '0;
			for (int i = 0; i < NCTX; i++) fill_q[i] <= '0;
			for (int i = 0; i < NUM_TASKS; i++) prio_q[i] <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == S_DONE;
			if (cfg_valid && cfg_ready) ext_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (start) req_q <= req;
				end
				S_READ: begin
					// pick context, fill count and the top-of-stack read address
					ctx_q <= task_ctx ? CW'(tid) : CW'(NUM_TASKS);
					n_q <= fill_sel;
					k_q <= (req_q.mode == MODE_REL) ? fill_sel - FW'(1) : '0;
					st_q <= chk_st;
					commit_q <= chk_ok;
				end
				S_TOP: begin
					// fill count known: check full and empty stack, set walk length
					if (commit_q && req_q.mode == MODE_GET && 32'(n_q) >= NUM_RESOURCES) begin
						st_q <= ST_ACCESS;
						commit_q <= 1'b0;
					end else if (commit_q && req_q.mode == MODE_REL && n_q == '0) begin
						st_q <= ST_NOFUNC;
						commit_q <= 1'b0;
					end
					case (req_q.mode)
						MODE_REL:     lim_q <= n_q - FW'(1);
						MODE_REL_INT: lim_q <= n_q;
						default:      lim_q <= '0;
					endcase
				end
				S_CHECK: begin
					// rd_q now holds the top entry for a release
					k_q <= '0;
					vld_q <= 1'b0;
					if (commit_q) begin
						case (req_q.mode)
							MODE_GET: begin
								taken_q[rid] <= 1'b1;
								fill_q[ctx_q] <= n_q + FW'(1);
								if (!is_isr && req_q.resource_prio > prio_q[tid])
									prio_q[tid] <= req_q.resource_prio;
							end
							MODE_REL: begin
								if (!top_ok) begin
									st_q <= ST_NOFUNC;
									commit_q <= 1'b0;
								end else begin
									taken_q[rid] <= 1'b0;
									fill_q[ctx_q] <= n_q - FW'(1);
								end
							end
							MODE_GET_INT: begin
								int_q[tid] <= 1'b1;
								if (req_q.internal_prio > prio_q[tid])
									prio_q[tid] <= req_q.internal_prio;
							end
							default: begin
								int_q[tid] <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN: begin
					// walk entries; read data follows its address in the next cycle
					k_q <= k_q + FW'(1);
					vld_q <= k_q < lim_q;
				end
				S_DONE: begin
					rsp_q.status <= st_q;
					rsp_q.reschedule <= commit_q && req_q.mode == MODE_REL;
					if (commit_q && req_q.mode[0] && task_ctx) begin
						prio_q[tid] <= m_acc;
						rsp_q.current_prio <= m_acc;
					end else begin
						rsp_q.current_prio <= tvalid ? prio_q[tid] : 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

// ===== src/pcrm_max_unit.sv =====
// Running-maximum unit: one compare per cycle.
module pcrm_max_unit import pcrm_pkg::*; (
	input  logic       clk,
	input  logic       load,
	input  logic [7:0] load_val,
	input  logic       step,
	input  logic [7:0] step_val,
	output logic [7:0] acc
);
	logic [7:0] acc_q;

	// load the base, then fold in one ceiling per step
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= load_val;
		end else if (step && step_val > acc_q) begin
			acc_q <= step_val;
		end
	end

	assign acc = acc_q;
endmodule
